>>> design/hs_pkg.sv
// ============================================================================
// Heap sort package
// Shared constants for the heap sort block and its store.
// ============================================================================
`default_nettype none

package hs_pkg;

    // Width of one element and of one sorted result.
    localparam int DATA_W = 32;

    // Default capacity of the heap store.
    localparam int DEPTH_DEF = 64;

endpackage : hs_pkg

`default_nettype wire

>>> design/hs_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with a registered read.
// ============================================================================
`default_nettype none

module hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule : hs_ram

`default_nettype wire

>>> design/heap_sort.sv
// ============================================================================
// Heap sort
// Collects a set of signed values, heapsorts them in one RAM and emits them.
// ============================================================================
// Loading accepts transactions until the one marked last closes the set.
// Sorting is paced by the single read port of the heap RAM: each sift level reads the
// left child, reads the right child, then compares and moves.
// Each sorted result is read from the RAM, captured and then held until m_tready takes it.
// Reset (rst_n low, asynchronous) empties the set; the RAM content is not cleared.
`default_nettype none

module heap_sort
    import hs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    // Input stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic              s_tlast,   // is_last

    // Output stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,   // last_of_run
    output logic                   m_tuser    // [0] overflowed
);

    // Address width of the store and width of a count that can hold DEPTH itself.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // The sequencer. LOAD accepts elements. BUILD_RD/BUILD_LD fetch the node that
    // starts a sift during heap construction. SIFT_L/SIFT_R/SIFT_C form one sift
    // level: read left child, read right child, compare and move. SWAP_RK, SWAP_R0
    // and SWAP_WK exchange the root with the last unsorted slot. EMIT_* read the
    // sorted store out one value at a time.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_BUILD_RD,
        ST_BUILD_LD,
        ST_SIFT_L,
        ST_SIFT_R,
        ST_SIFT_C,
        ST_SWAP_RK,
        ST_SWAP_R0,
        ST_SWAP_WK,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_OUT
    } state_t;

    state_t            state_reg;
    logic [CW-1:0]     count_reg;      // elements stored in the open set
    logic              ovf_reg;        // an element of the open set was dropped
    logic              run_ovf_reg;    // overflow flag of the set being sorted
    logic [CW-1:0]     n_reg;          // size of the set being sorted
    logic [CW-1:0]     k_reg;          // build: node index + 1, sort: swapped slot
    logic [CW-1:0]     size_reg;       // heap size of the current sift
    logic [CW-1:0]     pos_reg;        // hole position of the current sift
    logic              phase_sort_reg; // 0 while building the heap, 1 while sorting
    logic [CW-1:0]     idx_reg;        // next slot to emit
    logic              out_valid_reg;
    logic              out_last_reg;

    // Payload registers.
    logic [DATA_W-1:0] cur_reg;        // value being sifted down
    logic [DATA_W-1:0] lc_val_reg;     // value of the left child
    logic [DATA_W-1:0] out_data_reg;

    // RAM port signals.
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // Datapath signals.
    logic              in_fire;
    logic              has_room;
    logic [CW-1:0]     count_inc;
    logic [CW:0]       lc_idx;
    logic [CW:0]       rc_idx;
    logic [CW:0]       size_ext;
    logic              lc_ok;
    logic              rc_ok;
    logic              lc_gt;
    logic [DATA_W-1:0] best_val;
    logic              rc_gt;
    logic              move_down;
    logic [CW-1:0]     top_idx;
    logic [DATA_W-1:0] top_val;
    logic              sift_end;

    hs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Inputs are taken only while the set is open; nothing else happens then.
    assign s_tready  = (state_reg == ST_LOAD);
    assign in_fire   = s_tvalid && s_tready;
    assign has_room  = (count_reg < CW'(DEPTH));
    assign count_inc = has_room ? (count_reg + CW'(1)) : count_reg;

    // Children of the hole position, one bit wider than a count so they never wrap.
    assign lc_idx   = {pos_reg, 1'b1};
    assign rc_idx   = {pos_reg, 1'b0} + (CW + 1)'(2);
    assign size_ext = {1'b0, size_reg};
    assign lc_ok    = (lc_idx < size_ext);
    assign rc_ok    = (rc_idx < size_ext);

    // The compare step sees the left child in lc_val_reg and the right child on
    // the RAM read data. The larger child moves up when it beats the sifted value.
    assign lc_gt     = ($signed(lc_val_reg) > $signed(cur_reg));
    assign best_val  = lc_gt ? lc_val_reg : cur_reg;
    assign rc_gt     = rc_ok && ($signed(mem_rdata) > $signed(best_val));
    assign move_down = lc_gt || rc_gt;
    assign top_idx   = rc_gt ? rc_idx[CW-1:0] : lc_idx[CW-1:0];
    assign top_val   = rc_gt ? mem_rdata : lc_val_reg;

    // A sift ends when the hole has no child or neither child is larger.
    assign sift_end = ((state_reg == ST_SIFT_L) && !lc_ok) ||
                      ((state_reg == ST_SIFT_C) && !move_down);

    // RAM control. No write lands in the same cycle as a read whose data is used,
    // so the read-before-write behavior of the RAM never shows.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg[AW-1:0];
        mem_wdata = cur_reg;
        mem_raddr = pos_reg[AW-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                mem_we    = in_fire && has_room;
                mem_waddr = count_reg[AW-1:0];
                mem_wdata = s_tdata;
            end
            ST_SIFT_L:
            begin
                mem_we    = !lc_ok;
                mem_raddr = lc_idx[AW-1:0];
            end
            ST_SIFT_R:
            begin
                mem_raddr = rc_idx[AW-1:0];
            end
            ST_SIFT_C:
            begin
                mem_we    = 1'b1;
                mem_wdata = move_down ? top_val : cur_reg;
            end
            ST_SWAP_RK:
            begin
                mem_raddr = k_reg[AW-1:0];
            end
            ST_SWAP_R0:
            begin
                mem_raddr = '0;
            end
            ST_SWAP_WK:
            begin
                // The old root goes to the end of the unsorted part.
                mem_we    = 1'b1;
                mem_waddr = k_reg[AW-1:0];
                mem_wdata = mem_rdata;
            end
            ST_EMIT_RD:
            begin
                mem_raddr = idx_reg[AW-1:0];
            end
            ST_BUILD_RD,
            ST_BUILD_LD,
            ST_EMIT_CAP,
            ST_EMIT_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer and registered control outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            run_ovf_reg    <= 1'b0;
            n_reg          <= '0;
            k_reg          <= '0;
            size_reg       <= '0;
            pos_reg        <= '0;
            phase_sort_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else if (sift_end)
        begin
            if (!phase_sort_reg)
            begin
                if (k_reg > CW'(1))
                begin
                    k_reg     <= k_reg - CW'(1);
                    pos_reg   <= k_reg - CW'(2);
                    state_reg <= ST_BUILD_RD;
                end
                else
                begin
                    // Heap is built; start swapping from the last slot.
                    phase_sort_reg <= 1'b1;
                    k_reg          <= n_reg - CW'(1);
                    state_reg      <= ST_SWAP_RK;
                end
            end
            else
            begin
                if (k_reg > CW'(1))
                begin
                    k_reg     <= k_reg - CW'(1);
                    state_reg <= ST_SWAP_RK;
                end
                else
                begin
                    idx_reg   <= '0;
                    state_reg <= ST_EMIT_RD;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (s_tlast)
                        begin
                            // Close the set and clear it for the next one.
                            count_reg      <= '0;
                            ovf_reg        <= 1'b0;
                            run_ovf_reg    <= ovf_reg || !has_room;
                            n_reg          <= count_inc;
                            size_reg       <= count_inc;
                            k_reg          <= count_inc >> 1;
                            pos_reg        <= (count_inc >> 1) - CW'(1);
                            phase_sort_reg <= 1'b0;
                            idx_reg        <= '0;
                            if (count_inc >= CW'(2))
                            begin
                                state_reg <= ST_BUILD_RD;
                            end
                            else if (count_inc == CW'(1))
                            begin
                                state_reg <= ST_EMIT_RD;
                            end
                        end
                        else
                        begin
                            count_reg <= count_inc;
                            ovf_reg   <= ovf_reg || !has_room;
                        end
                    end
                end
                ST_BUILD_RD:
                begin
                    state_reg <= ST_BUILD_LD;
                end
                ST_BUILD_LD:
                begin
                    state_reg <= ST_SIFT_L;
                end
                ST_SIFT_L:
                begin
                    state_reg <= ST_SIFT_R;
                end
                ST_SIFT_R:
                begin
                    state_reg <= ST_SIFT_C;
                end
                ST_SIFT_C:
                begin
                    // The larger child moved up into the hole; follow it down.
                    pos_reg   <= top_idx;
                    state_reg <= ST_SIFT_L;
                end
                ST_SWAP_RK:
                begin
                    state_reg <= ST_SWAP_R0;
                end
                ST_SWAP_R0:
                begin
                    state_reg <= ST_SWAP_WK;
                end
                ST_SWAP_WK:
                begin
                    pos_reg   <= '0;
                    size_reg  <= k_reg;
                    state_reg <= ST_SIFT_L;
                end
                ST_EMIT_RD:
                begin
                    state_reg <= ST_EMIT_CAP;
                end
                ST_EMIT_CAP:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= ((idx_reg + CW'(1)) == n_reg);
                    state_reg     <= ST_EMIT_OUT;
                end
                ST_EMIT_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // Payload registers follow the sequencer and need no reset.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_BUILD_LD,
            ST_SWAP_R0:
            begin
                // Building: the node itself. Swapping: the value from the last slot.
                cur_reg <= mem_rdata;
            end
            ST_SIFT_R:
            begin
                lc_val_reg <= mem_rdata;
            end
            ST_EMIT_CAP:
            begin
                out_data_reg <= mem_rdata;
            end
            ST_LOAD,
            ST_BUILD_RD,
            ST_SIFT_L,
            ST_SIFT_C,
            ST_SWAP_RK,
            ST_SWAP_WK,
            ST_EMIT_RD,
            ST_EMIT_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = run_ovf_reg;

    // Input and output never run at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("input ready while a result is pending");

    // The fill count of the open set never passes the store capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // The hole of a sift always lies inside the heap being sifted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT_L) |-> (pos_reg < size_reg))
        else $error("sift position outside the heap");

    // After the final result of a set the block returns to accepting input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not reopen after the final result");

endmodule : heap_sort

`default_nettype wire

>>> dv/heap_sort_checker.sv
// ============================================================================
// Heap sort checker
// Watches both streams of the heap sort block, predicts the sorted output of
// every closed set and compares each result transaction against it.
// ============================================================================

module heap_sort_checker
    import hs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic              s_tlast,   // is_last

    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    input  wire logic              m_tlast,   // last_of_run
    input  wire logic              m_tuser,   // [0] overflowed

    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_of_run;
        logic                     overflowed;
    } sorted_item_t;

    // Values of the set that is still open, in arrival order.
    logic signed [DATA_W-1:0] set_store [DEPTH];
    int                       set_count;
    logic                     set_dropped;

    // Sorted values still owed by the block, oldest first.
    sorted_item_t             pending_sorted [$];

    // Sorts the open set ascending and queues one result per stored value.
    function automatic void sort_open_set();
        logic signed [DATA_W-1:0] ordered [DEPTH];
        logic signed [DATA_W-1:0] key;
        int                       j;
        sorted_item_t             item;
        for (int i = 0; i < set_count; i++)
        begin
            key = set_store[i];
            j = i;
            while (j > 0 && ordered[j-1] > key)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = key;
        end
        for (int i = 0; i < set_count; i++)
        begin
            item.sorted_value = ordered[i];
            item.last_of_run  = (i == set_count - 1);
            item.overflowed   = set_dropped;
            pending_sorted.push_back(item);
        end
    endfunction

    // A value arriving at a full store is dropped but marks the whole set.
    function automatic void take_element(logic signed [DATA_W-1:0] value, logic closes);
        if (set_count < DEPTH)
        begin
            set_store[set_count] = value;
            set_count++;
        end
        else
        begin
            set_dropped = 1'b1;
        end
        if (closes)
        begin
            sort_open_set();
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endfunction

    function automatic void check_result();
        sorted_item_t want;
        if (pending_sorted.size() == 0)
        begin
            $error("unexpected result transaction: sorted_value %0d",
                   $signed(m_tdata));
            fail_count++;
        end
        else
        begin
            want = pending_sorted.pop_front();
            if (m_tdata !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, actual %0d",
                       want.sorted_value, $signed(m_tdata));
                fail_count++;
            end
            if (m_tlast !== want.last_of_run)
            begin
                $error("last_of_run: expected %0b, actual %0b", want.last_of_run, m_tlast);
                fail_count++;
            end
            if (m_tuser !== want.overflowed)
            begin
                $error("overflowed: expected %0b, actual %0b", want.overflowed, m_tuser);
                fail_count++;
            end
        end
    endfunction

    // Results are checked before the input of the same edge is taken, since a
    // result accepted now can only belong to a set closed earlier.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            set_count   = 0;
            set_dropped = 1'b0;
            pending_sorted.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
            end
            if (s_tvalid && s_tready)
            begin
                take_element(s_tdata, s_tlast);
            end
        end
        pending = pending_sorted.size();
    end

endmodule

>>> dv/tb.sv
// ============================================================================
// Heap sort testbench
// Feeds sets of signed values to the heap sort block under varying idle and
// stall patterns and lets a checker compare every sorted result.
// ============================================================================

module tb;

    import hs_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 280;     // stimulus stops after about this many
    localparam int PHASE_ITEMS    = 40;      // items per idling phase
    localparam int HOLD_START     = 5;       // cycles before the long receiver hold-off
    localparam int HOLD_CYCLES    = 400;     // length of that hold-off
    localparam int DRAIN_CYCLES   = 200;     // quiet time after the last expected result
    localparam int WATCHDOG_LIMIT = 20000;   // cycles without any transaction

    logic              clk = 1'b0;
    logic              rst_n;

    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;    // [31:0] value
    logic              s_tlast;    // is_last

    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;    // [31:0] sorted_value
    logic              m_tlast;    // last_of_run
    logic              m_tuser;    // [0] overflowed

    int                fail_count;
    int                pending;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int                send_idle_pct = 0;
    int                stall_pct     = 0;

    int                quiet_cycles  = 0;
    int                random_items;
    int                set_len;
    int                set_index;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    heap_sort #(
        .DEPTH (DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    heap_sort_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The run is stopped when neither stream moves for too long: the block
    // is stuck or has lost results.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL heap_sort");
            $finish;
        end
    end

    // Receiver. Early in the run it holds m_tready low for a long stretch
    // while the sender keeps offering values, so the block has to hold back
    // its sorted output and then stall its input. After that it stalls at the
    // rate the current phase asks for.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        m_tready <= 1'b1;
        repeat (HOLD_START) @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        forever
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
            @(negedge clk);
        end
    end

    // Offers one value and returns at the falling edge after the transaction.
    // tvalid is only lowered for an idle cycle, never dropped and raised again
    // in the same step.
    task automatic push_element(input logic [DATA_W-1:0] value, input logic closes);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= closes;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Value mixes: full range, a narrow band full of duplicates, and the
    // extremes of the signed range.
    function automatic logic [DATA_W-1:0] pick_value(input int mix);
        logic [DATA_W-1:0] value;
        case (mix)
            1:       value = $urandom_range(0, 6) - 3;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = '0;
                    3:       value = '1;
                    default: value = $urandom;
                endcase
            end
            default: value = $urandom;
        endcase
        return value;
    endfunction

    task automatic send_set(input int count, input int mix);
        for (int i = 0; i < count; i++)
        begin
            push_element(pick_value(mix), i == count - 1);
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed sets. A set of one value is the smallest the block sees.
        push_element(32'h7FFF_FFFF, 1'b1);
        // Both extremes, zero, minus one and repeated values in one set.
        push_element(32'h0000_0000, 1'b0);
        push_element(32'hFFFF_FFFF, 1'b0);
        push_element(32'h8000_0000, 1'b0);
        push_element(32'h7FFF_FFFF, 1'b0);
        push_element(32'h0000_0001, 1'b0);
        push_element(32'h8000_0001, 1'b0);
        push_element(32'h7FFF_FFFF, 1'b0);
        push_element(32'h8000_0000, 1'b0);
        push_element(32'h0000_0000, 1'b1);
        // Two values of opposite sign, already out of order.
        push_element(32'd5, 1'b0);
        push_element(-32'sd5, 1'b1);
        // A descending run, which is already a heap, so the build moves nothing.
        for (int i = 6; i >= 0; i--)
        begin
            push_element(i, i == 0);
        end
        // All values equal.
        push_element(32'hA5A5_A5A5, 1'b0);
        push_element(32'hA5A5_A5A5, 1'b0);
        push_element(32'hA5A5_A5A5, 1'b1);

        // Random sets, mostly short. One set fills the store exactly and one
        // overflows it so that even the value marked last is dropped; a few
        // more full or overflowing sets come at random.
        random_items = 0;
        set_index    = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ((random_items / PHASE_ITEMS) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 49;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 49;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            if (set_index == 3)
            begin
                set_len = DEPTH;
            end
            else if (set_index == 8)
            begin
                set_len = DEPTH + 3;
            end
            else if ($urandom_range(0, 99) < 3)
            begin
                set_len = DEPTH + $urandom_range(0, 2);
            end
            else
            begin
                set_len = $urandom_range(1, 12);
            end
            send_set(set_len, $urandom_range(0, 2));
            random_items += set_len;
            set_index++;
        end
        s_tvalid <= 1'b0;

        // Let every owed result arrive, then watch a while for stray ones.
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS heap_sort");
        end
        else
        begin
            $display("FAIL heap_sort");
        end
        $finish;
    end

endmodule
